// File: hw/rtl/mtt_pkg.sv
package mtt_pkg;

    // Table size and derived widths.
    localparam int TIMER_SLOTS     = 16;
    localparam int SLOT_W          = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W           = $clog2(TIMER_SLOTS + 1);
    localparam int MAX_EXP_REPORTS = 16;
    localparam int EXP_W           = $clog2(MAX_EXP_REPORTS + 1);

    // Operation codes.
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    // Result kinds.
    localparam logic [2:0] K_REGISTERED = 3'd0;
    localparam logic [2:0] K_REPLACED   = 3'd1;
    localparam logic [2:0] K_FULL       = 3'd2;
    localparam logic [2:0] K_REMOVED    = 3'd3;
    localparam logic [2:0] K_NOT_FOUND  = 3'd4;
    localparam logic [2:0] K_EXPIRED    = 3'd5;
    localparam logic [2:0] K_TICK_DONE  = 3'd6;
    localparam logic [2:0] K_BAD_PERIOD = 3'd7;

    // One timer entry, as held by a cell of the ring.
    typedef struct packed {
        logic        active;
        logic [7:0]  owner_id;
        logic [15:0] reload_value;
        logic [15:0] remaining;
        logic        repeat_flag;
    } t_entry;

    // Slot number as reported on the result port, masked to four bits.
    function automatic logic [3:0] to_slot4(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+3:0] w;
        w = {4'b0000, s};
        return w[3:0];
    endfunction

endpackage

// File: hw/rtl/mtt_cell.sv
module mtt_cell
    import mtt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_next,
    output t_entry o_entry
);

    t_entry r_entry;

    // Take the neighbour's entry on every shift; hold otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: hw/rtl/mtt_ctrl.sv
module mtt_ctrl
    import mtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_service_id,
    input  logic [15:0] i_period_ticks,
    input  logic        i_periodic,
    input  t_entry      i_head,
    output t_entry      o_tail,
    output logic        o_shift,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_service_id_out,
    output logic [3:0]  o_slot,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_WRITE,
        S_UNREG,
        S_TICK,
        S_TDONE
    } t_state;

    t_state            r_state,       n_state;
    logic [CNT_W-1:0]  r_cnt,         n_cnt;
    logic [7:0]        r_id,          n_id;
    logic [15:0]       r_period,      n_period;
    logic              r_rep,         n_rep;
    logic              r_match_found, n_match_found;
    logic [SLOT_W-1:0] r_match_slot,  n_match_slot;
    logic              r_free_found,  n_free_found;
    logic [SLOT_W-1:0] r_free_slot,   n_free_slot;
    logic [EXP_W-1:0]  r_nexp,        n_nexp;
    logic              r_strobe,      n_strobe;
    logic [2:0]        r_kind,        n_kind;
    logic [7:0]        r_sid,         n_sid;
    logic [3:0]        r_slot,        n_slot;
    logic              r_last,        n_last;

    logic [SLOT_W-1:0] idx;
    logic              last_step;
    logic              hit;
    logic              have_slot;
    logic [SLOT_W-1:0] tslot;
    logic [15:0]       dec;

    // The head cell always holds the slot whose number equals the step count.
    assign idx       = r_cnt[SLOT_W-1:0];
    assign last_step = (r_cnt == CNT_W'(TIMER_SLOTS - 1));
    assign hit       = i_head.active && (i_head.owner_id == r_id);
    assign have_slot = r_match_found || r_free_found;
    assign tslot     = r_match_found ? r_match_slot : r_free_slot;
    assign dec       = i_head.remaining - 16'd1;

    assign busy    = (r_state != S_IDLE);
    assign o_shift = (r_state == S_SEARCH) || (r_state == S_WRITE) ||
                     (r_state == S_UNREG)  || (r_state == S_TICK);

    // Sequencer and head-of-ring processing.
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_id          = r_id;
        n_period      = r_period;
        n_rep         = r_rep;
        n_match_found = r_match_found;
        n_match_slot  = r_match_slot;
        n_free_found  = r_free_found;
        n_free_slot   = r_free_slot;
        n_nexp        = r_nexp;
        n_strobe      = 1'b0;
        n_kind        = r_kind;
        n_sid         = r_sid;
        n_slot        = r_slot;
        n_last        = r_last;
        o_tail        = i_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_id          = i_service_id;
                    n_period      = i_period_ticks;
                    n_rep         = i_periodic;
                    n_cnt         = '0;
                    n_match_found = 1'b0;
                    n_free_found  = 1'b0;
                    n_nexp        = '0;
                    case (i_opcode)
                        OP_REGISTER: begin
                            if (i_period_ticks == 16'd0) begin
                                n_strobe = 1'b1;
                                n_kind   = K_BAD_PERIOD;
                                n_sid    = i_service_id;
                                n_slot   = 4'd0;
                                n_last   = 1'b1;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        OP_UNREGISTER: n_state = S_UNREG;
                        OP_TICK:       n_state = S_TICK;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end

            // First pass: find a live entry with this id and the first free slot.
            S_SEARCH: begin
                if (hit && !r_match_found) begin
                    n_match_found = 1'b1;
                    n_match_slot  = idx;
                end
                if (!i_head.active && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_slot  = idx;
                end
                if (last_step) begin
                    n_cnt   = '0;
                    n_state = S_WRITE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            // Second pass: load the chosen slot as it goes by.
            S_WRITE: begin
                if (have_slot && (idx == tslot)) begin
                    o_tail.active       = 1'b1;
                    o_tail.owner_id     = r_id;
                    o_tail.reload_value = r_period;
                    o_tail.remaining    = r_period;
                    o_tail.repeat_flag  = r_rep;
                end
                if (last_step) begin
                    n_strobe = 1'b1;
                    n_sid    = r_id;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    n_cnt    = '0;
                    if (r_match_found) begin
                        n_kind = K_REPLACED;
                        n_slot = to_slot4(tslot);
                    end else if (r_free_found) begin
                        n_kind = K_REGISTERED;
                        n_slot = to_slot4(tslot);
                    end else begin
                        n_kind = K_FULL;
                        n_slot = 4'd0;
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            // Single pass: clear the first live entry with this id.
            S_UNREG: begin
                if (hit && !r_match_found) begin
                    o_tail        = '0;
                    n_match_found = 1'b1;
                    n_match_slot  = idx;
                end
                if (last_step) begin
                    n_strobe = 1'b1;
                    n_sid    = r_id;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    n_cnt    = '0;
                    if (n_match_found) begin
                        n_kind = K_REMOVED;
                        n_slot = to_slot4(n_match_slot);
                    end else begin
                        n_kind = K_NOT_FOUND;
                        n_slot = 4'd0;
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            // Single pass: count down each live entry and report expiries.
            S_TICK: begin
                if (i_head.active) begin
                    o_tail.remaining = dec;
                    if (dec == 16'd0) begin
                        if (r_nexp < EXP_W'(MAX_EXP_REPORTS)) begin
                            n_strobe = 1'b1;
                            n_kind   = K_EXPIRED;
                            n_sid    = i_head.owner_id;
                            n_slot   = to_slot4(idx);
                            n_last   = 1'b0;
                            n_nexp   = r_nexp + EXP_W'(1);
                        end
                        if (i_head.repeat_flag) begin
                            o_tail.remaining = i_head.reload_value;
                        end else begin
                            o_tail.active = 1'b0;
                        end
                    end
                end
                if (last_step) begin
                    n_cnt   = '0;
                    n_state = S_TDONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            // Close the tick.
            S_TDONE: begin
                n_strobe = 1'b1;
                n_kind   = K_TICK_DONE;
                n_sid    = 8'd0;
                n_slot   = 4'd0;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_nexp        <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_id          <= n_id;
            r_period      <= n_period;
            r_rep         <= n_rep;
            r_match_found <= n_match_found;
            r_match_slot  <= n_match_slot;
            r_free_found  <= n_free_found;
            r_free_slot   <= n_free_slot;
            r_nexp        <= n_nexp;
            r_strobe      <= n_strobe;
            r_kind        <= n_kind;
            r_sid         <= n_sid;
            r_slot        <= n_slot;
            r_last        <= n_last;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_kind           = r_kind;
    assign o_service_id_out = r_sid;
    assign o_slot           = r_slot;
    assign o_last           = r_last;

    // A tick transfer always starts the countdown pass.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_TICK) |=> (r_state == S_TICK))
        else $error("tick transfer did not start the countdown pass");

    // The closing result of an item is shown only once the block is idle again.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |-> (r_state == S_IDLE))
        else $error("final result shown while the block is still busy");

    // Expiry reports are never final; tick done always is.
    a_expiry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_kind == K_EXPIRED) |-> !r_last)
        else $error("expiry result marked as last");

    a_tick_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_kind == K_TICK_DONE) |-> r_last)
        else $error("tick done result not marked as last");

    // The ring only moves while a pass is running, and the step count stays in range.
    a_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shift |-> (busy && r_cnt < CNT_W'(TIMER_SLOTS)))
        else $error("ring shifted outside a pass or step count out of range");

endmodule

// File: hw/rtl/multi_timer_table.sv
// Timer table: a cell ring that rotates one slot per cycle past a head unit during a pass.
// Tick: a countdown pass, then tick done; expiries are shown one at a time during the pass.
// Unregister: one pass of the ring; register: two passes (search, then load).
// Zero-period register: no pass; a final result shows in the cycle after its last step.
// The receiver cannot stall; results are single-cycle strobes on o_strobe.
// Synchronous active-low reset clears every cell and returns the sequencer to idle.
module multi_timer_table
    import mtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_service_id,
    input  logic [15:0] i_period_ticks,
    input  logic        i_periodic,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_service_id_out,
    output logic [3:0]  o_slot,
    output logic        o_last
);

    t_entry cell_q [TIMER_SLOTS];
    t_entry tail;
    logic   shift;

    // Ring of timer cells: each takes its upper neighbour, the top takes the head result.
    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        t_entry nxt;
        if (g == TIMER_SLOTS - 1) begin : g_top
            assign nxt = tail;
        end else begin : g_mid
            assign nxt = cell_q[g+1];
        end
        mtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_next  (nxt),
            .o_entry (cell_q[g])
        );
    end

    // Sequencer and head unit.
    mtt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_service_id     (i_service_id),
        .i_period_ticks   (i_period_ticks),
        .i_periodic       (i_periodic),
        .i_head           (cell_q[0]),
        .o_tail           (tail),
        .o_shift          (shift),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_service_id_out (o_service_id_out),
        .o_slot           (o_slot),
        .o_last           (o_last)
    );

endmodule

// File: dv/multi_timer_table_test.sv
module multi_timer_table_test
    import mtt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    // Slowest item is a register (two passes of the ring) plus the longest gap,
    // taken many times over for roughly 360 items.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 3 * TIMER_SLOTS + 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 42;

    // Opcode that the block is meant to ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] id;
        logic [3:0] slot;
        logic       last;
    } t_timer_result;

    // Scoreboard: keeps its own copy of the timer table and the results still due.
    class timer_scoreboard;
        t_timer_result due_results[$];
        bit            slot_on[TIMER_SLOTS];
        logic [7:0]    slot_owner[TIMER_SLOTS];
        logic [15:0]   slot_reload[TIMER_SLOTS];
        logic [15:0]   slot_left[TIMER_SLOTS];
        bit            slot_repeat[TIMER_SLOTS];
        int mismatches;
        int items_seen;
        int results_seen;
        int expiries;
        int full_refusals;

        function new();
            for (int s = 0; s < TIMER_SLOTS; s++) begin
                clear_slot(s);
            end
            mismatches    = 0;
            items_seen    = 0;
            results_seen  = 0;
            expiries      = 0;
            full_refusals = 0;
        endfunction

        function void clear_slot(int s);
            slot_on[s]     = 1'b0;
            slot_owner[s]  = '0;
            slot_reload[s] = '0;
            slot_left[s]   = '0;
            slot_repeat[s] = 1'b0;
        endfunction

        function void queue_result(logic [2:0] kind, logic [7:0] id, int s, logic last);
            t_timer_result r;
            r.kind = kind;
            r.id   = id;
            r.slot = s[3:0];
            r.last = last;
            due_results.push_back(r);
        endfunction

        function int find_owner(logic [7:0] id);
            for (int s = 0; s < TIMER_SLOTS; s++) begin
                if (slot_on[s] && slot_owner[s] == id) begin
                    return s;
                end
            end
            return -1;
        endfunction

        // Work out every result that one accepted transfer causes.
        function void note_input(logic [1:0] op, logic [7:0] id, logic [15:0] period,
                                 logic periodic);
            int s;
            int n;
            logic [2:0] kind;
            items_seen++;
            case (op)
                OP_REGISTER: begin
                    if (period == 16'd0) begin
                        queue_result(K_BAD_PERIOD, id, 0, 1'b1);
                        return;
                    end
                    s = find_owner(id);
                    if (s >= 0) begin
                        kind = K_REPLACED;
                    end else begin
                        kind = K_REGISTERED;
                        for (s = 0; s < TIMER_SLOTS; s++) begin
                            if (!slot_on[s]) break;
                        end
                        if (s >= TIMER_SLOTS) begin
                            full_refusals++;
                            queue_result(K_FULL, id, 0, 1'b1);
                            return;
                        end
                    end
                    slot_on[s]     = 1'b1;
                    slot_owner[s]  = id;
                    slot_reload[s] = period;
                    slot_left[s]   = period;
                    slot_repeat[s] = periodic;
                    queue_result(kind, id, s, 1'b1);
                end
                OP_UNREGISTER: begin
                    s = find_owner(id);
                    if (s < 0) begin
                        queue_result(K_NOT_FOUND, id, 0, 1'b1);
                    end else begin
                        clear_slot(s);
                        queue_result(K_REMOVED, id, s, 1'b1);
                    end
                end
                OP_TICK: begin
                    n = 0;
                    for (s = 0; s < TIMER_SLOTS; s++) begin
                        if (!slot_on[s]) continue;
                        slot_left[s] = slot_left[s] - 16'd1;
                        if (slot_left[s] == 16'd0) begin
                            if (n < MAX_EXP_REPORTS) begin
                                queue_result(K_EXPIRED, slot_owner[s], s, 1'b0);
                                n++;
                                expiries++;
                            end
                            if (slot_repeat[s]) begin
                                slot_left[s] = slot_reload[s];
                            end else begin
                                slot_on[s] = 1'b0;
                            end
                        end
                    end
                    queue_result(K_TICK_DONE, 8'd0, 0, 1'b1);
                end
                default: begin
                    // The unused opcode leaves the table alone and gives nothing back.
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Compare one result, field by field, with the oldest one still due.
        task check_result(logic [2:0] kind, logic [7:0] id, logic [3:0] slot, logic last);
            t_timer_result due;
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d id %0d slot %0d last %0d",
                                          kind, id, slot, last));
                return;
            end
            due = due_results.pop_front();
            if (kind !== due.kind)
                report_mismatch($sformatf("kind %0d, wanted %0d", kind, due.kind));
            if (id !== due.id)
                report_mismatch($sformatf("service id %0d, wanted %0d", id, due.id));
            if (slot !== due.slot)
                report_mismatch($sformatf("slot %0d, wanted %0d", slot, due.slot));
            if (last !== due.last)
                report_mismatch($sformatf("last %0d, wanted %0d", last, due.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [7:0]  i_service_id;
    logic [15:0] i_period_ticks;
    logic        i_periodic;
    logic        o_strobe;
    logic [2:0]  o_kind;
    logic [7:0]  o_service_id_out;
    logic [3:0]  o_slot;
    logic        o_last;

    timer_scoreboard sb;
    int cycle_count;

    multi_timer_table DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_service_id     (i_service_id),
        .i_period_ticks   (i_period_ticks),
        .i_periodic       (i_periodic),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_service_id_out (o_service_id_out),
        .o_slot           (o_slot),
        .o_last           (o_last)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            sb.check_result(o_kind, o_service_id_out, o_slot, o_last);
        end
    end

    // Mostly short gaps, now and then a long one; none at all in the no-idle phases.
    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one item and hold it until the block takes it; called just after a rising edge.
    task automatic transfer_item(input logic [1:0] op, input logic [7:0] id,
                                 input logic [15:0] period, input logic periodic,
                                 input int gap);
        i_opcode       <= op;
        i_service_id   <= id;
        i_period_ticks <= period;
        i_periodic     <= periodic;
        start          <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        sb.note_input(op, id, period, periodic);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stimulus: a directed opening, then random phases with varying id pools.
    initial begin
        int pool_size;
        int pool_base;
        int period_max;
        int r;
        bit no_idle;
        logic [1:0]  op;
        logic [7:0]  id;
        logic [15:0] period;
        logic        periodic;

        sb = new();
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OP_TICK;
        i_service_id   = '0;
        i_period_ticks = '0;
        i_periodic     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, zero period, extreme id and period, replacement, absent id, unused op.
        transfer_item(OP_TICK, 8'd0, 16'd0, 1'b0, pick_gap(0));
        transfer_item(OP_REGISTER, 8'd0, 16'd0, 1'b1, pick_gap(0));
        transfer_item(OP_REGISTER, 8'd255, 16'd65535, 1'b1, pick_gap(0));
        transfer_item(OP_REGISTER, 8'd255, 16'd1, 1'b1, pick_gap(0));
        transfer_item(OP_UNREGISTER, 8'd0, 16'hFFFF, 1'b1, pick_gap(0));
        transfer_item(OP_UNUSED, 8'hA5, 16'h5A5A, 1'b1, pick_gap(0));

        // Fill the rest of the table, then overflow it.
        for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
            transfer_item(OP_REGISTER, i[7:0], 16'd1, i[0], pick_gap(0));
        end
        transfer_item(OP_REGISTER, 8'd200, 16'd3, 1'b0, pick_gap(0));

        // Every slot expires on the first tick; only the periodic ones on the next.
        transfer_item(OP_TICK, 8'hFF, 16'hFFFF, 1'b1, pick_gap(0));
        transfer_item(OP_TICK, 8'd0, 16'd0, 1'b0, pick_gap(0));
        transfer_item(OP_UNREGISTER, 8'd255, 16'd0, 1'b0, pick_gap(0));

        // Random phases: register and tick heavy, with some removals and noise.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       pool_size = 3;
                1:       pool_size = 8;
                2:       pool_size = 24;
                default: pool_size = 256;
            endcase
            case ($urandom_range(0, 2))
                0:       period_max = 2;
                1:       period_max = 6;
                default: period_max = 40;
            endcase
            pool_base = $urandom_range(0, 255);
            no_idle   = (phase % 3 == 1);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r        = $urandom_range(0, 99);
                id       = 8'(pool_base + $urandom_range(0, pool_size - 1));
                period   = 16'($urandom_range(0, 65535));
                periodic = 1'($urandom_range(0, 1));
                if (r < 3) begin
                    op = OP_UNUSED;
                end else if (r < 43) begin
                    op = OP_REGISTER;
                    r  = $urandom_range(0, 99);
                    if (r < 4)
                        period = 16'd0;
                    else if (r >= 12)
                        period = 16'($urandom_range(1, period_max));
                end else if (r < 60) begin
                    op = OP_UNREGISTER;
                    if ($urandom_range(0, 9) == 0)
                        id = 8'($urandom_range(0, 255));
                end else begin
                    op = OP_TICK;
                end
                transfer_item(op, id, period, periodic, pick_gap(no_idle));
            end
        end
        start <= 1'b0;

        // Let the last results come out, then watch for stray ones.
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d accepted transfers and %0d results, among them %0d expiries",
                 sb.items_seen, sb.results_seen, sb.expiries);
        $display("and %0d full-table refusals; %0d mismatches found.",
                 sb.full_refusals, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
